[hdl/trhit_pkg.sv]
// ----------------------------------------------------------------------------
// trhit_pkg
// Shared types and codes of the triangle hit-region classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package trhit_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_VERTEX0_X    = 3'd0;
    localparam logic [2:0] CFG_VERTEX0_Y    = 3'd1;
    localparam logic [2:0] CFG_VERTEX1_X    = 3'd2;
    localparam logic [2:0] CFG_VERTEX1_Y    = 3'd3;
    localparam logic [2:0] CFG_VERTEX2_X    = 3'd4;
    localparam logic [2:0] CFG_VERTEX2_Y    = 3'd5;
    localparam logic [2:0] CFG_PAD_MARGIN   = 3'd6;
    localparam logic [2:0] CFG_HANDLE_SCOPE = 3'd7;

    localparam int SCOPE_BITS  = 8;
    localparam int MARGIN_BITS = 8;

    typedef enum logic [1:0] {
        REGION_OUTSIDE = 2'd0,
        REGION_HANDLE  = 2'd1,
        REGION_NEAR    = 2'd2,
        REGION_INSIDE  = 2'd3
    } region_t;

    // Per-stage load enables of the classification pipeline
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
        logic s5_en;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

[hdl/trhit_cfg.sv]
// ----------------------------------------------------------------------------
// trhit_cfg
// Configuration registers and the geometry derived from them: edge deltas,
// padded bounding box and the handle / near-box bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module trhit_cfg #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [2:0]                             cfg_index,
    input  wire logic [COORD_BITS-1:0]                  cfg_data,
    output logic      [2:0][COORD_BITS-1:0]             bx,
    output logic      [2:0][COORD_BITS-1:0]             by,
    output logic      [2:0][COORD_BITS:0]               dx,
    output logic      [2:0][COORD_BITS:0]               dy,
    output logic      [COORD_BITS+2:0]                  hx_lo,
    output logic      [COORD_BITS+2:0]                  hx_hi,
    output logic      [COORD_BITS+2:0]                  hy_lo,
    output logic      [COORD_BITS+2:0]                  hy_hi,
    output logic      [COORD_BITS+2:0]                  nx_lo,
    output logic      [COORD_BITS+2:0]                  ny_lo
);

    localparam int XW = COORD_BITS + 1;
    localparam int BW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] vx_reg [3];
    logic [COORD_BITS-1:0] vy_reg [3];
    logic [trhit_pkg::MARGIN_BITS-1:0] margin_reg;
    logic [trhit_pkg::SCOPE_BITS-1:0]  scope_reg;

    logic [COORD_BITS-1:0] min_x, min_y, max_x, max_y, margin_ext;
    logic [XW-1:0] half_ext;
    logic [XW-1:0] left_next, top_next, right_next, bottom_next;
    logic [XW-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [2:0][XW-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [BW-1:0] left_s, top_s, right_s, bottom_s, scope_s;
    logic [BW-1:0] hx_lo_reg, hx_hi_reg, hy_lo_reg, hy_hi_reg, nx_lo_reg, ny_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
            margin_reg <= '0;
            scope_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                trhit_pkg::CFG_VERTEX0_X:    vx_reg[0]  <= cfg_data;
                trhit_pkg::CFG_VERTEX0_Y:    vy_reg[0]  <= cfg_data;
                trhit_pkg::CFG_VERTEX1_X:    vx_reg[1]  <= cfg_data;
                trhit_pkg::CFG_VERTEX1_Y:    vy_reg[1]  <= cfg_data;
                trhit_pkg::CFG_VERTEX2_X:    vx_reg[2]  <= cfg_data;
                trhit_pkg::CFG_VERTEX2_Y:    vy_reg[2]  <= cfg_data;
                trhit_pkg::CFG_PAD_MARGIN:   margin_reg <= cfg_data[trhit_pkg::MARGIN_BITS-1:0];
                trhit_pkg::CFG_HANDLE_SCOPE: scope_reg  <= cfg_data[trhit_pkg::SCOPE_BITS-1:0];
            endcase
        end
    end

    // Bounding box, padded per side when the side lies beyond the margin
    always_comb
    begin
        min_x = (vx_reg[0] < vx_reg[1]) ? vx_reg[0] : vx_reg[1];
        min_x = (vx_reg[2] < min_x) ? vx_reg[2] : min_x;
        min_y = (vy_reg[0] < vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        min_y = (vy_reg[2] < min_y) ? vy_reg[2] : min_y;
        max_x = (vx_reg[0] > vx_reg[1]) ? vx_reg[0] : vx_reg[1];
        max_x = (vx_reg[2] > max_x) ? vx_reg[2] : max_x;
        max_y = (vy_reg[0] > vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        max_y = (vy_reg[2] > max_y) ? vy_reg[2] : max_y;

        margin_ext = COORD_BITS'(margin_reg);
        half_ext   = XW'(margin_reg[trhit_pkg::MARGIN_BITS-1:1]);

        left_next   = XW'(min_x) - ((min_x > margin_ext) ? half_ext : '0);
        top_next    = XW'(min_y) - ((min_y > margin_ext) ? half_ext : '0);
        right_next  = XW'(max_x) + ((max_x > margin_ext) ? half_ext : '0);
        bottom_next = XW'(max_y) + ((max_y > margin_ext) ? half_ext : '0);

        for (int i = 0; i < 3; i++)
        begin
            // edge i runs from vertex i (a) to vertex i+1 (b)
            dx_next[i] = XW'(vx_reg[i]) - XW'(vx_reg[(i + 1) % 3]);
            dy_next[i] = XW'(vy_reg[i]) - XW'(vy_reg[(i + 1) % 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        top_reg    <= top_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
    end

    assign left_s   = $signed(BW'(left_reg));
    assign top_s    = $signed(BW'(top_reg));
    assign right_s  = $signed(BW'(right_reg));
    assign bottom_s = $signed(BW'(bottom_reg));
    assign scope_s  = $signed(BW'(scope_reg));

    always_ff @(posedge clk)
    begin
        hx_lo_reg <= BW'(right_s - scope_s);
        hx_hi_reg <= BW'(right_s + scope_s);
        hy_lo_reg <= BW'(bottom_s - scope_s);
        hy_hi_reg <= BW'(bottom_s + scope_s);
        nx_lo_reg <= BW'(left_s - scope_s);
        ny_lo_reg <= BW'(top_s - scope_s);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bx[i] = vx_reg[(i + 1) % 3];
            by[i] = vy_reg[(i + 1) % 3];
        end
    end

    assign dx    = dx_reg;
    assign dy    = dy_reg;
    assign hx_lo = hx_lo_reg;
    assign hx_hi = hx_hi_reg;
    assign hy_lo = hy_lo_reg;
    assign hy_hi = hy_hi_reg;
    assign nx_lo = nx_lo_reg;
    assign ny_lo = ny_lo_reg;

endmodule

`default_nettype wire

[hdl/trhit_datapath.sv]
// ----------------------------------------------------------------------------
// trhit_datapath
// Five-stage classification datapath: point offsets, edge products,
// signs and box tests, then the priority pick of the region code.
// ----------------------------------------------------------------------------
`default_nettype none

module trhit_datapath #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                       clk,
    input  wire trhit_pkg::pipe_ctrl_t      ctrl,
    input  wire logic [COORD_BITS-1:0]      query_x,
    input  wire logic [COORD_BITS-1:0]      query_y,
    input  wire logic [2:0][COORD_BITS-1:0] bx,
    input  wire logic [2:0][COORD_BITS-1:0] by,
    input  wire logic [2:0][COORD_BITS:0]   dx,
    input  wire logic [2:0][COORD_BITS:0]   dy,
    input  wire logic [COORD_BITS+2:0]      hx_lo,
    input  wire logic [COORD_BITS+2:0]      hx_hi,
    input  wire logic [COORD_BITS+2:0]      hy_lo,
    input  wire logic [COORD_BITS+2:0]      hy_hi,
    input  wire logic [COORD_BITS+2:0]      nx_lo,
    input  wire logic [COORD_BITS+2:0]      ny_lo,
    output trhit_pkg::region_t              region
);

    localparam int XW = COORD_BITS + 1;
    localparam int PW = 2 * XW;
    localparam int DW = PW + 1;
    localparam int BW = COORD_BITS + 3;

    // stage 1: captured point
    logic [COORD_BITS-1:0] s1_qx_reg, s1_qy_reg;
    // stage 2: offsets from each edge's end vertex
    logic [COORD_BITS-1:0] s2_qx_reg, s2_qy_reg;
    logic [2:0][XW-1:0]    s2_ex_reg, s2_ey_reg, s2_ex_next, s2_ey_next;
    // stage 3: the two products of each edge function
    logic [COORD_BITS-1:0] s3_qx_reg, s3_qy_reg;
    logic [2:0][PW-1:0]    s3_pa_reg, s3_pb_reg, s3_pa_next, s3_pb_next;
    // stage 4: sign summary and box tests
    logic s4_neg_reg, s4_pos_reg, s4_hit_reg, s4_near_reg;
    logic s4_neg_next, s4_pos_next, s4_hit_next, s4_near_next;
    // stage 5: result
    trhit_pkg::region_t s5_region_reg, s5_region_next;

    logic signed [DW-1:0] edge_d [3];
    logic signed [BW-1:0] qx_s, qy_s;

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            s1_qx_reg <= query_x;
            s1_qy_reg <= query_y;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_ex_next[i] = XW'(s1_qx_reg) - XW'(bx[i]);
            s2_ey_next[i] = XW'(s1_qy_reg) - XW'(by[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_en)
        begin
            s2_qx_reg <= s1_qx_reg;
            s2_qy_reg <= s1_qy_reg;
            s2_ex_reg <= s2_ex_next;
            s2_ey_reg <= s2_ey_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_pa_next[i] = PW'($signed(s2_ex_reg[i]) * $signed(dy[i]));
            s3_pb_next[i] = PW'($signed(dx[i]) * $signed(s2_ey_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s3_en)
        begin
            s3_qx_reg <= s2_qx_reg;
            s3_qy_reg <= s2_qy_reg;
            s3_pa_reg <= s3_pa_next;
            s3_pb_reg <= s3_pb_next;
        end
    end

    // Zero counts as either sign, so only strictly signed values matter
    always_comb
    begin
        s4_neg_next = 1'b0;
        s4_pos_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            edge_d[i] = DW'($signed(s3_pa_reg[i])) - DW'($signed(s3_pb_reg[i]));
            s4_neg_next = s4_neg_next | edge_d[i][DW-1];
            s4_pos_next = s4_pos_next | (!edge_d[i][DW-1] && (edge_d[i] != '0));
        end

        qx_s = $signed(BW'(s3_qx_reg));
        qy_s = $signed(BW'(s3_qy_reg));
        s4_hit_next  = (qx_s >= $signed(hx_lo)) && (qx_s <= $signed(hx_hi)) &&
                       (qy_s >= $signed(hy_lo)) && (qy_s <= $signed(hy_hi));
        s4_near_next = (qx_s >= $signed(nx_lo)) && (qx_s <= $signed(hx_hi)) &&
                       (qy_s >= $signed(ny_lo)) && (qy_s <= $signed(hy_hi));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s4_en)
        begin
            s4_neg_reg  <= s4_neg_next;
            s4_pos_reg  <= s4_pos_next;
            s4_hit_reg  <= s4_hit_next;
            s4_near_reg <= s4_near_next;
        end
    end

    always_comb
    begin
        priority if (s4_hit_reg)
            s5_region_next = trhit_pkg::REGION_HANDLE;
        else if (!(s4_neg_reg && s4_pos_reg))
            s5_region_next = trhit_pkg::REGION_INSIDE;
        else if (s4_near_reg)
            s5_region_next = trhit_pkg::REGION_NEAR;
        else
            s5_region_next = trhit_pkg::REGION_OUTSIDE;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s5_en)
            s5_region_reg <= s5_region_next;
    end

    assign region = s5_region_reg;

endmodule

`default_nettype wire

[hdl/triangle_hit_region_test_core.sv]
// ----------------------------------------------------------------------------
// triangle_hit_region_test_core
// Classifies query points against a configured triangle and its padded
// bounding box: resize handle, inside triangle, near box or outside.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                | Word
//   ---------+--------------------------+----------------------------------
//   query in | in_valid / in_stall      | query_x, query_y (COORD_BITS each)
//   result   | out_valid / out_stall    | region (2 bits)
//   config   | cfg_we (no back-pressure)| cfg_index (3 bits), cfg_data
//
// out_valid rises once the accepted word reaches the last stage; one word enters
// every cycle while the result side keeps up.
// Reset clears the configuration registers and all stage valid bits.
// A stall holds only the full stages from the output back to the first
// empty one; that one keeps filling, so bubbles are squeezed out.
// Box bounds trail a write via padded box registers; pipeline depth covers it.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_hit_region_test_core #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data,
    // query word in
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COORD_BITS-1:0] query_x,
    input  wire logic [COORD_BITS-1:0] query_y,
    // result word out
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 region
);

    localparam int XW = COORD_BITS + 1;
    localparam int BW = COORD_BITS + 3;

    logic [2:0][COORD_BITS-1:0] bx, by;
    logic [2:0][XW-1:0]         dx, dy;
    logic [BW-1:0]              hx_lo, hx_hi, hy_lo, hy_hi, nx_lo, ny_lo;

    trhit_pkg::pipe_ctrl_t ctrl;
    trhit_pkg::region_t    region_code;

    // One valid bit per stage, travelling alongside the datapath registers
    logic [5:1] valid_reg, valid_next;

    // Load a stage when it is empty or when its word moves on
    always_comb
    begin
        ctrl.s5_en = !valid_reg[5] || !out_stall;
        ctrl.s4_en = !valid_reg[4] || ctrl.s5_en;
        ctrl.s3_en = !valid_reg[3] || ctrl.s4_en;
        ctrl.s2_en = !valid_reg[2] || ctrl.s3_en;
        ctrl.s1_en = !valid_reg[1] || ctrl.s2_en;

        valid_next    = valid_reg;
        if (ctrl.s1_en) valid_next[1] = in_valid;
        if (ctrl.s2_en) valid_next[2] = valid_reg[1];
        if (ctrl.s3_en) valid_next[3] = valid_reg[2];
        if (ctrl.s4_en) valid_next[4] = valid_reg[3];
        if (ctrl.s5_en) valid_next[5] = valid_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Registers and the derived triangle / box geometry
    trhit_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bx        (bx),
        .by        (by),
        .dx        (dx),
        .dy        (dy),
        .hx_lo     (hx_lo),
        .hx_hi     (hx_hi),
        .hy_lo     (hy_lo),
        .hy_hi     (hy_hi),
        .nx_lo     (nx_lo),
        .ny_lo     (ny_lo)
    );

    // Point classification pipeline
    trhit_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk     (clk),
        .ctrl    (ctrl),
        .query_x (query_x),
        .query_y (query_y),
        .bx      (bx),
        .by      (by),
        .dx      (dx),
        .dy      (dy),
        .hx_lo   (hx_lo),
        .hx_hi   (hx_hi),
        .hy_lo   (hy_lo),
        .hy_hi   (hy_hi),
        .nx_lo   (nx_lo),
        .ny_lo   (ny_lo),
        .region  (region_code)
    );

    assign in_stall  = !ctrl.s1_en;
    assign out_valid = valid_reg[5];
    assign region    = region_code;

endmodule

`default_nettype wire
